/* hdl/rpd_pkg.sv */
// Shared types, codes and a helper function for the radiation packet decoder.
package rpd_pkg;

    // Packet framing constants
    localparam int unsigned PKT_LEN      = 30;
    localparam int unsigned REC_FIRST    = 5;
    localparam int unsigned REC_END      = 29;
    localparam int unsigned REC_BYTES    = 6;
    localparam int unsigned NUM_REC      = 4;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned LEVEL_W      = 36;
    localparam int unsigned MIN_LEVEL_W  = 31;
    localparam int unsigned ANGLE_W      = 9;

    // Status byte bit positions
    localparam int unsigned BIT_HIGH_FAULT = 0;
    localparam int unsigned BIT_LOW_FAULT  = 1;
    localparam int unsigned BIT_LINK_LOST  = 4;
    localparam int unsigned BIT_SCALE      = 7;

    // Record byte lanes
    localparam int unsigned LANE_STAT   = 4;
    localparam int unsigned LANE_STATUS = 5;

    // Source angles in degrees
    localparam logic [ANGLE_W-1:0] ANGLE_0   = 9'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_45  = 9'd45;
    localparam logic [ANGLE_W-1:0] ANGLE_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_135 = 9'd135;
    localparam logic [ANGLE_W-1:0] ANGLE_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_225 = 9'd225;
    localparam logic [ANGLE_W-1:0] ANGLE_315 = 9'd315;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_LEN = 2'd1,
        STATUS_SUM = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_RX,
        ST_LEVEL,
        ST_TEST,
        ST_ANGLE,
        ST_EMIT,
        ST_ERR
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       rx_accept;
        logic       finish;
        logic       calc_level;
        logic       run_test;
        logic       set_angle;
        logic       load_rec;
        logic       load_err;
        logic [1:0] idx;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic len_ok;
        logic sum_ok;
        logic out_free;
    } dp_stat_t;

    // Record slot of a byte position: record number in the upper bits, lane below.
    function automatic logic [4:0] rec_slot(input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] off;
        logic [1:0]       rec;
        logic [CNT_W-1:0] lane;
        begin
            off = pos - CNT_W'(REC_FIRST);
            if (off < CNT_W'(REC_BYTES))
            begin
                rec  = 2'd0;
                lane = off;
            end
            else if (off < CNT_W'(2 * REC_BYTES))
            begin
                rec  = 2'd1;
                lane = off - CNT_W'(REC_BYTES);
            end
            else if (off < CNT_W'(3 * REC_BYTES))
            begin
                rec  = 2'd2;
                lane = off - CNT_W'(2 * REC_BYTES);
            end
            else
            begin
                rec  = 2'd3;
                lane = off - CNT_W'(3 * REC_BYTES);
            end
            rec_slot = {rec, lane[2:0]};
        end
    endfunction

endpackage

/* hdl/rpd_ctrl.sv */
// Sequencing state machine for the radiation packet decoder.
module rpd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  rpd_pkg::dp_stat_t stat,
    output rpd_pkg::dp_cmd_t  cmd
);

    rpd_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]           idx_reg, idx_next;

    // State and record counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpd_pkg::ST_RX;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        s_tready   = 1'b0;
        case (state_reg)
            rpd_pkg::ST_RX:
            begin
                s_tready = 1'b1;
                idx_next = 2'd0;
                if (s_tvalid)
                begin
                    if (s_tlast)
                    begin
                        cmd.finish = 1'b1;
                        state_next = (stat.len_ok && stat.sum_ok) ? rpd_pkg::ST_LEVEL
                                                                  : rpd_pkg::ST_ERR;
                    end
                    else
                    begin
                        cmd.rx_accept = 1'b1;
                    end
                end
            end
            rpd_pkg::ST_LEVEL:
            begin
                cmd.calc_level = 1'b1;
                idx_next       = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = rpd_pkg::ST_TEST;
                end
            end
            rpd_pkg::ST_TEST:
            begin
                cmd.run_test = 1'b1;
                idx_next     = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = rpd_pkg::ST_ANGLE;
                end
            end
            rpd_pkg::ST_ANGLE:
            begin
                cmd.set_angle = 1'b1;
                idx_next      = 2'd0;
                state_next    = rpd_pkg::ST_EMIT;
            end
            rpd_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_rec = 1'b1;
                    idx_next     = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = rpd_pkg::ST_RX;
                    end
                end
            end
            rpd_pkg::ST_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = rpd_pkg::ST_RX;
                end
            end
            default:
            begin
                state_next = rpd_pkg::ST_RX;
            end
        endcase
    end

endmodule

/* hdl/rpd_datapath.sv */
// Byte collection, checksum, record store, level and angle logic, output register.
module rpd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          s_tdata,
    input  logic                                cfg_we,
    input  logic [rpd_pkg::MIN_LEVEL_W-1:0]     cfg_wdata,
    input  rpd_pkg::dp_cmd_t                    cmd,
    output rpd_pkg::dp_stat_t                   stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    localparam int unsigned LW = rpd_pkg::LEVEL_W;
    localparam int unsigned AW = rpd_pkg::ANGLE_W;

    // Control and accumulator registers
    logic [rpd_pkg::CNT_W-1:0]       byte_count_reg;
    logic [7:0]                      sum_low_reg;
    logic [8:0]                      sum_running_reg;
    logic [rpd_pkg::MIN_LEVEL_W-1:0] min_level_reg;
    logic [AW-1:0]                   held_angle_reg;
    logic                            out_valid_reg;

    // Payload registers
    logic [7:0]           rec_reg [rpd_pkg::NUM_REC][rpd_pkg::REC_BYTES];
    logic signed [LW-1:0] lv_reg [rpd_pkg::NUM_REC];
    logic [3:0]           test_reg;
    logic                 danger_reg;
    logic                 upd_reg;
    rpd_pkg::status_t     err_reg;

    // Output item register
    rpd_pkg::status_t     o_status_reg;
    logic [1:0]           o_index_reg;
    logic signed [LW-1:0] o_value_reg;
    logic [7:0]           o_stat_reg;
    logic                 o_high_reg;
    logic                 o_low_reg;
    logic                 o_link_reg;
    logic                 o_danger_reg;
    logic [AW-1:0]        o_angle_reg;
    logic                 o_upd_reg;
    logic                 o_last_reg;

    logic [8:0]           run_sum;
    logic [4:0]           slot;
    logic                 store_en;
    logic [7:0]           rd [rpd_pkg::REC_BYTES];
    logic signed [LW-1:0] raw_ext;
    logic signed [LW-1:0] level;
    logic                 level_ge;
    logic signed [LW-1:0] ta;
    logic signed [LW-1:0] tb;
    logic signed [LW:0]   ta_ext;
    logic signed [LW:0]   tb_dbl;
    logic                 test_pass;
    logic                 fb, rl, bf, lr;
    logic [AW-1:0]        angle_new;
    logic                 angle_hit;

    // Handshake status for the controller
    assign stat.len_ok   = (byte_count_reg == rpd_pkg::CNT_W'(rpd_pkg::PKT_LEN - 1));
    assign stat.sum_ok   = (sum_low_reg == s_tdata);
    assign stat.out_free = !out_valid_reg || m_tready;

    // Running sum and record slot of the incoming byte
    assign run_sum  = sum_running_reg + {1'b0, s_tdata};
    assign slot     = rpd_pkg::rec_slot(byte_count_reg);
    assign store_en = cmd.rx_accept
                    && (byte_count_reg >= rpd_pkg::CNT_W'(rpd_pkg::REC_FIRST))
                    && (byte_count_reg <  rpd_pkg::CNT_W'(rpd_pkg::REC_END));

    // Byte counter, checksum sums, config, angle and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            sum_low_reg     <= '0;
            sum_running_reg <= '0;
            min_level_reg   <= '0;
            held_angle_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_level_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                byte_count_reg  <= '0;
                sum_low_reg     <= '0;
                sum_running_reg <= '0;
            end
            else if (cmd.rx_accept)
            begin
                if (byte_count_reg != '1)
                begin
                    byte_count_reg <= byte_count_reg + 1'b1;
                end
                if (run_sum > 9'd255)
                begin
                    sum_low_reg     <= sum_low_reg + s_tdata + 8'd1;
                    sum_running_reg <= '0;
                end
                else
                begin
                    sum_low_reg     <= sum_low_reg + s_tdata;
                    sum_running_reg <= run_sum;
                end
            end
            if (cmd.set_angle && angle_hit)
            begin
                held_angle_reg <= angle_new;
            end
            if (cmd.load_rec || cmd.load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Record store, one byte lane written per accepted record byte
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            rec_reg[slot[4:3]][slot[2:0]] <= s_tdata;
        end
    end

    // One record read port, addressed by the controller's record counter
    always_comb
    begin
        for (int i = 0; i < rpd_pkg::REC_BYTES; i++)
        begin
            rd[i] = rec_reg[cmd.idx][i];
        end
    end

    // Level: signed little-endian word, times ten when the scale bit is set
    assign raw_ext  = LW'($signed({rd[3], rd[2], rd[1], rd[0]}));
    assign level    = rd[rpd_pkg::LANE_STATUS][rpd_pkg::BIT_SCALE]
                    ? (raw_ext <<< 3) + (raw_ext <<< 1) : raw_ext;
    assign level_ge = (level >= $signed({{(LW - rpd_pkg::MIN_LEVEL_W){1'b0}}, min_level_reg}));

    // Ratio test operands: front/back, right/left, back/front, left/right
    always_comb
    begin
        case (cmd.idx)
            2'd0:
            begin
                ta = lv_reg[0];
                tb = lv_reg[1];
            end
            2'd1:
            begin
                ta = lv_reg[3];
                tb = lv_reg[2];
            end
            2'd2:
            begin
                ta = lv_reg[1];
                tb = lv_reg[0];
            end
            default:
            begin
                ta = lv_reg[2];
                tb = lv_reg[3];
            end
        endcase
    end

    // a/b > 2 without division; a zero divisor reduces to a > 0
    assign ta_ext    = {ta[LW-1], ta};
    assign tb_dbl    = {tb, 1'b0};
    assign test_pass = tb[LW-1] ? (ta_ext < tb_dbl) : (ta_ext > tb_dbl);

    // Angle selection from the four ratio tests
    assign fb = test_reg[0];
    assign rl = test_reg[1];
    assign bf = test_reg[2];
    assign lr = test_reg[3];

    always_comb
    begin
        angle_hit = 1'b1;
        angle_new = rpd_pkg::ANGLE_0;
        if (fb)
        begin
            angle_new = rl ? rpd_pkg::ANGLE_315 : (lr ? rpd_pkg::ANGLE_225 : rpd_pkg::ANGLE_180);
        end
        else if (rl)
        begin
            angle_new = bf ? rpd_pkg::ANGLE_45 : rpd_pkg::ANGLE_0;
        end
        else if (bf)
        begin
            angle_new = lr ? rpd_pkg::ANGLE_135 : rpd_pkg::ANGLE_90;
        end
        else if (lr)
        begin
            angle_new = rpd_pkg::ANGLE_180;
        end
        else
        begin
            angle_hit = 1'b0;
        end
    end

    // Per-packet work registers
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            err_reg <= stat.len_ok ? rpd_pkg::STATUS_SUM : rpd_pkg::STATUS_LEN;
        end
        if (cmd.calc_level)
        begin
            lv_reg[cmd.idx] <= level;
            danger_reg      <= (cmd.idx == 2'd0) ? level_ge : (danger_reg || level_ge);
        end
        if (cmd.run_test)
        begin
            test_reg[cmd.idx] <= test_pass;
        end
        if (cmd.set_angle)
        begin
            upd_reg <= angle_hit;
        end
    end

    // Output item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_rec)
        begin
            o_status_reg <= rpd_pkg::STATUS_OK;
            o_index_reg  <= cmd.idx;
            o_value_reg  <= lv_reg[cmd.idx];
            o_stat_reg   <= rd[rpd_pkg::LANE_STAT];
            o_high_reg   <= rd[rpd_pkg::LANE_STATUS][rpd_pkg::BIT_HIGH_FAULT];
            o_low_reg    <= rd[rpd_pkg::LANE_STATUS][rpd_pkg::BIT_LOW_FAULT];
            o_link_reg   <= rd[rpd_pkg::LANE_STATUS][rpd_pkg::BIT_LINK_LOST];
            o_danger_reg <= danger_reg;
            o_angle_reg  <= held_angle_reg;
            o_upd_reg    <= upd_reg;
            o_last_reg   <= (cmd.idx == 2'd3);
        end
        else if (cmd.load_err)
        begin
            o_status_reg <= err_reg;
            o_index_reg  <= '0;
            o_value_reg  <= '0;
            o_stat_reg   <= '0;
            o_high_reg   <= 1'b0;
            o_low_reg    <= 1'b0;
            o_link_reg   <= 1'b0;
            o_danger_reg <= 1'b0;
            o_angle_reg  <= held_angle_reg;
            o_upd_reg    <= 1'b0;
            o_last_reg   <= 1'b1;
        end
    end

    // Output ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {4'd0, o_upd_reg, o_angle_reg, o_danger_reg, o_link_reg,
                       o_low_reg, o_high_reg, o_stat_reg, o_value_reg, o_index_reg};

endmodule

/* hdl/radiation_packet_decoder.sv */
// Top level of the radiation packet decoder: controller plus datapath.
//
//  Channel   Direction  Item
//  s_*       in         one packet byte; s_tlast marks the final byte
//  m_*       out        one record result or one error result; m_tlast ends a packet
//  cfg_*     in         write of min_level, danger threshold in hundredths
//
// Each non-final byte is taken as soon as it is offered in the receive state.
// The final byte of a good packet starts a walk of the four stored records: a
// level calculation for each record, four ratio tests and the angle selection,
// then four results, one per cycle while m_tready is high. A bad packet gives one
// error result. No bytes are taken until the last result is in the output register.
// rst_n clears counters, sums, the threshold, the held angle and the output valid.
module radiation_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [1:0] sensor_index, [37:2] value_hundredths,
                                    // [45:38] stat_error, [46] high_sens_fault,
                                    // [47] low_sens_fault, [48] link_lost, [49] danger,
                                    // [58:50] angle_deg, [59] angle_updated
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata
);

    rpd_pkg::dp_cmd_t  cmd;
    rpd_pkg::dp_stat_t stat;

    // Sequencer
    rpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    rpd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the radiation packet decoder with a predicting scoreboard.
`timescale 1ns / 1ps

module testbench;

    // One result item as it leaves the block.
    typedef struct packed {
        rpd_pkg::status_t status;
        logic [1:0]       sensor;
        logic [35:0]      level;
        logic [7:0]       stat;
        logic             high_fault;
        logic             low_fault;
        logic             link_lost;
        logic             danger;
        logic [8:0]       angle;
        logic             angle_new;
        logic             ends_packet;
    } record_result_t;

    // One sensor record as it is placed into a packet.
    typedef struct {
        logic [31:0] raw;
        logic [7:0]  stat;
        logic [7:0]  flags;
    } sensor_rec_t;

    typedef logic [7:0] byte_list_t[$];

    // Tracks the decoder state byte by byte and holds the records it should emit.
    class packet_record_board;
        logic [30:0]    threshold;
        int unsigned    byte_count;
        logic [7:0]     sum_low;
        int unsigned    sum_running;
        logic [7:0]     rec_mem[24];
        logic [8:0]     held_angle;
        record_result_t awaited_records[$];
        int unsigned    failures;

        function new();
            threshold   = '0;
            byte_count  = 0;
            sum_low     = '0;
            sum_running = 0;
            held_angle  = '0;
            failures    = 0;
        endfunction

        // Signed level of one stored record, scaled by ten when the scale bit is set.
        function longint level_of(int k);
            logic [31:0] raw;
            longint      v;
            raw = {rec_mem[k * rpd_pkg::REC_BYTES + 3], rec_mem[k * rpd_pkg::REC_BYTES + 2],
                   rec_mem[k * rpd_pkg::REC_BYTES + 1], rec_mem[k * rpd_pkg::REC_BYTES]};
            v = longint'($signed(raw));
            if (rec_mem[k * rpd_pkg::REC_BYTES + rpd_pkg::LANE_STATUS][rpd_pkg::BIT_SCALE])
                v = v * 10;
            return v;
        endfunction

        // Exact test of a / b > 2, with a zero divisor passing only a positive a.
        function bit exceeds_double(longint a, longint b);
            if (b > 0)
                return a > 2 * b;
            if (b < 0)
                return a < 2 * b;
            return a > 0;
        endfunction

        function void push_error(rpd_pkg::status_t code);
            record_result_t r;
            r             = '0;
            r.status      = code;
            r.angle       = held_angle;
            r.ends_packet = 1'b1;
            awaited_records.push_back(r);
        endfunction

        // A good packet yields four records, the danger flag and the source angle.
        function void push_records();
            longint         lv[4];
            bit             hot;
            bit             fb, rl, bf, lr, upd;
            logic [8:0]     angle;
            logic [7:0]     flags;
            record_result_t r;
            hot = 1'b0;
            for (int k = 0; k < rpd_pkg::NUM_REC; k++)
            begin
                lv[k] = level_of(k);
                if (lv[k] >= longint'(threshold))
                    hot = 1'b1;
            end
            fb    = exceeds_double(lv[0], lv[1]);
            rl    = exceeds_double(lv[3], lv[2]);
            bf    = exceeds_double(lv[1], lv[0]);
            lr    = exceeds_double(lv[2], lv[3]);
            upd   = 1'b1;
            angle = rpd_pkg::ANGLE_0;
            if (fb)
                angle = rl ? rpd_pkg::ANGLE_315 : (lr ? rpd_pkg::ANGLE_225 : rpd_pkg::ANGLE_180);
            else if (rl)
                angle = bf ? rpd_pkg::ANGLE_45 : rpd_pkg::ANGLE_0;
            else if (bf)
                angle = lr ? rpd_pkg::ANGLE_135 : rpd_pkg::ANGLE_90;
            else if (lr)
                angle = rpd_pkg::ANGLE_180;
            else
                upd = 1'b0;
            if (upd)
                held_angle = angle;
            for (int k = 0; k < rpd_pkg::NUM_REC; k++)
            begin
                flags         = rec_mem[k * rpd_pkg::REC_BYTES + rpd_pkg::LANE_STATUS];
                r             = '0;
                r.status      = rpd_pkg::STATUS_OK;
                r.sensor      = 2'(k);
                r.level       = lv[k][35:0];
                r.stat        = rec_mem[k * rpd_pkg::REC_BYTES + rpd_pkg::LANE_STAT];
                r.high_fault  = flags[rpd_pkg::BIT_HIGH_FAULT];
                r.low_fault   = flags[rpd_pkg::BIT_LOW_FAULT];
                r.link_lost   = flags[rpd_pkg::BIT_LINK_LOST];
                r.danger      = hot;
                r.angle       = held_angle;
                r.angle_new   = upd;
                r.ends_packet = (k == rpd_pkg::NUM_REC - 1);
                awaited_records.push_back(r);
            end
        endfunction

        // Note one accepted input item.
        function void take_byte(logic [7:0] value, bit is_last);
            int unsigned total;
            logic [7:0]  chk;
            if (!is_last)
            begin
                if (byte_count >= rpd_pkg::REC_FIRST && byte_count < rpd_pkg::REC_END)
                    rec_mem[byte_count - rpd_pkg::REC_FIRST] = value;
                sum_low     = sum_low + value;
                sum_running = sum_running + value;
                if (sum_running > 255)
                begin
                    sum_low     = sum_low + 8'd1;
                    sum_running = 0;
                end
                if (byte_count < 31)
                    byte_count++;
                return;
            end
            total       = (byte_count < 31) ? byte_count + 1 : 31;
            chk         = sum_low;
            byte_count  = 0;
            sum_low     = '0;
            sum_running = 0;
            if (total != rpd_pkg::PKT_LEN)
                push_error(rpd_pkg::STATUS_LEN);
            else if (chk != value)
                push_error(rpd_pkg::STATUS_SUM);
            else
                push_records();
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        // Compare one accepted result item with the oldest awaited record.
        function void check_record(record_result_t got);
            record_result_t want;
            if (awaited_records.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d sensor %0d",
                         $time, got.status, got.sensor);
                failures++;
                return;
            end
            want = awaited_records.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("sensor_index", want.sensor, got.sensor);
            compare_field("value_hundredths", want.level, got.level);
            compare_field("stat_error", want.stat, got.stat);
            compare_field("high_sens_fault", want.high_fault, got.high_fault);
            compare_field("low_sens_fault", want.low_fault, got.low_fault);
            compare_field("link_lost", want.link_lost, got.link_lost);
            compare_field("danger", want.danger, got.danger);
            compare_field("angle_deg", want.angle, got.angle);
            compare_field("angle_updated", want.angle_new, got.angle_new);
            compare_field("last", want.ends_packet, got.ends_packet);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    packet_record_board board = new();
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    radiation_packet_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle cycles before the next item, with occasional stretches of none at all.
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Level generator that mixes small, large, zero, negative and extreme values.
    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 32'($urandom_range(0, 100));
            1: return 32'($urandom_range(1000, 1000000));
            2: return '0;
            3: return 32'(0 - $urandom_range(1, 100));
            4: return 32'(0 - $urandom_range(1000, 1000000));
            5: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($urandom());
        endcase
    endfunction

    function automatic void random_records(output sensor_rec_t recs[rpd_pkg::NUM_REC]);
        int twin;
        foreach (recs[k])
        begin
            recs[k].raw   = pick_level();
            recs[k].stat  = 8'($urandom_range(0, 255));
            recs[k].flags = 8'($urandom_range(0, 255));
        end
        // Sometimes put one level at twice its partner, give or take one, on the ratio edge.
        if ($urandom_range(0, 2) == 0)
        begin
            twin = $urandom_range(0, 3);
            recs[twin].raw = 32'(2 * recs[twin ^ 1].raw + $urandom_range(0, 2) - 1);
            recs[twin].flags[rpd_pkg::BIT_SCALE] = recs[twin ^ 1].flags[rpd_pkg::BIT_SCALE];
        end
    endfunction

    // Header, four records and a checksum byte that matches them.
    function automatic void build_good_packet(input sensor_rec_t recs[rpd_pkg::NUM_REC],
                                              output byte_list_t pkt);
        logic [7:0]  csum;
        int unsigned run;
        pkt = {};
        for (int i = 0; i < rpd_pkg::REC_FIRST; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
        foreach (recs[k])
        begin
            pkt.push_back(recs[k].raw[7:0]);
            pkt.push_back(recs[k].raw[15:8]);
            pkt.push_back(recs[k].raw[23:16]);
            pkt.push_back(recs[k].raw[31:24]);
            pkt.push_back(recs[k].stat);
            pkt.push_back(recs[k].flags);
        end
        csum = '0;
        run  = 0;
        foreach (pkt[i])
        begin
            csum = csum + pkt[i];
            run  = run + pkt[i];
            if (run > 255)
            begin
                csum = csum + 8'd1;
                run  = 0;
            end
        end
        pkt.push_back(csum);
    endfunction

    // Offer one item and wait for it to be taken.
    task automatic send_byte(input logic [7:0] value, input bit is_last);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        board.take_byte(value, is_last);
    endtask

    task automatic send_packet(input byte_list_t pkt);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Good packets mostly, with some broken checksums and wrong lengths.
    task automatic send_random_packet();
        sensor_rec_t recs[rpd_pkg::NUM_REC];
        byte_list_t  pkt;
        int          kind;
        int          len;
        kind = $urandom_range(0, 99);
        if (kind < 82)
        begin
            random_records(recs);
            build_good_packet(recs, pkt);
            if (kind >= 70)
                pkt[rpd_pkg::PKT_LEN - 1] ^= 8'($urandom_range(1, 255));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: len = rpd_pkg::PKT_LEN - 1;
                1: len = rpd_pkg::PKT_LEN + 1;
                2: len = $urandom_range(1, rpd_pkg::PKT_LEN - 2);
                default: len = $urandom_range(rpd_pkg::PKT_LEN + 2, 40);
            endcase
            pkt = {};
            repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
        end
        send_packet(pkt);
    endtask

    // Hold the sender until every awaited record is out, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.awaited_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_min_level(input logic [30:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.threshold = value;
    endtask

    // Receiver with random stalls.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(rx_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Check every accepted result item.
    always @(posedge clk)
    begin
        record_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status      = rpd_pkg::status_t'(m_tuser);
            got.sensor      = m_tdata[1:0];
            got.level       = m_tdata[37:2];
            got.stat        = m_tdata[45:38];
            got.high_fault  = m_tdata[46];
            got.low_fault   = m_tdata[47];
            got.link_lost   = m_tdata[48];
            got.danger      = m_tdata[49];
            got.angle       = m_tdata[58:50];
            got.angle_new   = m_tdata[59];
            got.ends_packet = m_tlast;
            board.check_record(got);
        end
    end

    // Stimulus: directed packets first, then random phases at several thresholds.
    initial
    begin
        sensor_rec_t recs[rpd_pkg::NUM_REC];
        byte_list_t  pkt;
        int unsigned bytes_sent;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // A lone final byte is a length error that still reports the reset angle.
        write_min_level('0);
        send_byte(8'hFF, 1'b1);

        // Largest and smallest scaled levels, all status bits, both stat extremes.
        recs[0] = '{32'h7FFFFFFF, 8'hFF, 8'hFF};
        recs[1] = '{32'h80000000, 8'h00, 8'h80};
        recs[2] = '{32'h80000000, 8'h5A, 8'h00};
        recs[3] = '{32'hFFFFFFFF, 8'hA5, 8'h13};
        build_good_packet(recs, pkt);
        send_packet(pkt);

        // Same packet against the highest threshold.
        write_min_level(31'h7FFFFFFF);
        send_packet(pkt);

        bytes_sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase % 2 == 0)
                write_min_level(31'($urandom_range(0, 2000)));
            else
                write_min_level(31'($urandom()));
            while (bytes_sent < (phase + 1) * 65)
            begin
                send_random_packet();
                bytes_sent += 30;
            end
        end

        drain_results();
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* radiation_packet_decoder.f */
hdl/rpd_pkg.sv
hdl/rpd_ctrl.sv
hdl/rpd_datapath.sv
hdl/radiation_packet_decoder.sv
sim/testbench.sv
